// ===== rtl/vsat_pkg.sv =====
// Shared types, opcodes and address masks of the video scroll address timing unit.
// Holds the address step functions used by the core. No dependencies.
`default_nettype none

package vsat_pkg;

    localparam int OPCODE_W = 3;
    localparam int BYTE_W   = 8;
    localparam int VADDR_W  = 16;
    localparam int TADDR_W  = 15;
    localparam int FINE_W   = 3;
    localparam int COUNT_W  = 9;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 64;

    localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_CTRL   = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_MASK   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SCROLL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ADDR   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_STATUS = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_DATA   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_NMIACK = 3'd7;

    localparam logic [TADDR_W-1:0] CTRL_KEEP     = 15'h73FF;
    localparam logic [TADDR_W-1:0] SCROLL2_KEEP  = 15'h0C1F;
    localparam logic [TADDR_W-1:0] SCROLL1_KEEP  = 15'h7FE0;
    localparam logic [TADDR_W-1:0] ADDR1_KEEP    = 15'h00FF;
    localparam logic [TADDR_W-1:0] ADDR2_KEEP    = 15'h7F00;
    localparam logic [VADDR_W-1:0] HORIZ_KEEP    = 16'h7BE0;
    localparam logic [VADDR_W-1:0] HORIZ_BITS    = 16'h041F;
    localparam logic [VADDR_W-1:0] NAMETABLE_X   = 16'h0400;
    localparam logic [VADDR_W-1:0] NAMETABLE_Y   = 16'h0800;
    localparam logic [VADDR_W-1:0] FINE_Y_BITS   = 16'h7000;
    localparam logic [VADDR_W-1:0] FINE_Y_ONE    = 16'h1000;
    localparam logic [VADDR_W-1:0] COARSE_Y_BITS = 16'h03E0;
    localparam logic [VADDR_W-1:0] COARSE_X_BITS = 16'h001F;
    localparam logic [VADDR_W-1:0] ROW_STEP      = 16'h0020;
    localparam logic [VADDR_W-1:0] COL_STEP      = 16'h0001;

    localparam logic [COUNT_W-1:0] LAST_DOT     = 9'd340;
    localparam logic [COUNT_W-1:0] LAST_LINE    = 9'd261;
    localparam logic [COUNT_W-1:0] VBLANK_LINE  = 9'd241;
    localparam logic [COUNT_W-1:0] VISIBLE_END  = 9'd240;
    localparam logic [COUNT_W-1:0] FETCH_FIRST  = 9'd1;
    localparam logic [COUNT_W-1:0] FETCH_END    = 9'd258;
    localparam logic [COUNT_W-1:0] PREFETCH_LO  = 9'd320;
    localparam logic [COUNT_W-1:0] PREFETCH_END = 9'd338;
    localparam logic [COUNT_W-1:0] FINE_Y_DOT   = 9'd256;
    localparam logic [COUNT_W-1:0] HCOPY_DOT    = 9'd257;
    localparam logic [COUNT_W-1:0] VCOPY_FIRST  = 9'd280;
    localparam logic [COUNT_W-1:0] VCOPY_LAST   = 9'd304;
    localparam logic [COUNT_W-1:0] FLAG_DOT     = 9'd1;

    localparam logic [4:0] ROW_LAST_VISIBLE = 5'd29;
    localparam logic [4:0] ROW_MAX          = 5'd31;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic [OPCODE_W-1:0] opcode;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] line_count;
        logic [COUNT_W-1:0] dot_count;
        logic               nmi_pending;
        logic [BYTE_W-1:0]  status_value;
        logic               toggle_state;
        logic [FINE_W-1:0]  fine_scroll_x;
        logic [TADDR_W-1:0] temp_address;
        logic [VADDR_W-1:0] current_address;
    } result_t;

    function automatic logic [VADDR_W-1:0] coarse_x_step(input logic [VADDR_W-1:0] v);
        logic [VADDR_W-1:0] r;
        if ((v & COARSE_X_BITS) == COARSE_X_BITS) begin
            r = (v & ~COARSE_X_BITS) ^ NAMETABLE_X;
        end else begin
            r = v + COL_STEP;
        end
        return r;
    endfunction

    function automatic logic [VADDR_W-1:0] fine_y_step(input logic [VADDR_W-1:0] v);
        logic [VADDR_W-1:0] r;
        logic [4:0]         row;
        if ((v & FINE_Y_BITS) != FINE_Y_BITS) begin
            r = v + FINE_Y_ONE;
        end else begin
            r   = v & ~FINE_Y_BITS;
            row = r[9:5];
            if (row == ROW_LAST_VISIBLE) begin
                row = 5'd0;
                r   = r ^ NAMETABLE_Y;
            end else if (row == ROW_MAX) begin
                row = 5'd0;
            end else begin
                row = row + 5'd1;
            end
            r[9:5] = row;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vsat_in_stage.sv =====
// Input register of the video scroll address timing unit.
// Captures one item from the slave stream; uses vsat_pkg.
`default_nettype none

module vsat_in_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  vsat_pkg::item_t       in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output vsat_pkg::item_t       out_item
);

    logic            valid_reg;
    logic            valid_next;
    vsat_pkg::item_t item_reg;

    // take a new item while empty or whenever the held one leaves in the same cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vsat_core.sv =====
// Scroll, address and raster state with its one-item update logic.
// Applies one item per enabled cycle and forms its result; uses vsat_pkg.
`default_nettype none

module vsat_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  vsat_pkg::item_t          item,
    output vsat_pkg::result_t        result
);

    logic [vsat_pkg::VADDR_W-1:0] vaddr_reg, vaddr_next;
    logic [vsat_pkg::TADDR_W-1:0] taddr_reg, taddr_next;
    logic [vsat_pkg::FINE_W-1:0]  fine_x_reg, fine_x_next;
    logic                         second_write_reg, second_write_next;
    logic                         vblank_reg, vblank_next;
    logic                         nmi_reg, nmi_next;
    logic                         nmi_enable_reg, nmi_enable_next;
    logic                         step_by_row_reg, step_by_row_next;
    logic                         render_on_reg, render_on_next;
    logic [vsat_pkg::COUNT_W-1:0] dot_reg, dot_next;
    logic [vsat_pkg::COUNT_W-1:0] line_reg, line_next;

    logic [vsat_pkg::TADDR_W-1:0] d15;
    logic                         render_line;
    logic                         fetch_window;
    logic [vsat_pkg::VADDR_W-1:0] v_tick;
    logic                         status_old;
    logic                         nmi_old;
    logic                         is_status;
    logic                         is_ack;

    assign d15 = {7'd0, item.data_byte};

    assign render_line  = (line_reg < vsat_pkg::VISIBLE_END) ||
                          (line_reg == vsat_pkg::LAST_LINE);
    assign fetch_window = ((dot_reg > vsat_pkg::FETCH_FIRST) &&
                           (dot_reg < vsat_pkg::FETCH_END)) ||
                          ((dot_reg > vsat_pkg::PREFETCH_LO) &&
                           (dot_reg < vsat_pkg::PREFETCH_END));

    // rendering-time address updates: coarse x, then fine y, then the copies
    always_comb begin
        v_tick = vaddr_reg;
        if (render_line && render_on_reg) begin
            if (fetch_window && (dot_reg[2:0] == 3'd0)) begin
                v_tick = vsat_pkg::coarse_x_step(v_tick);
            end
            if (dot_reg == vsat_pkg::FINE_Y_DOT) begin
                v_tick = vsat_pkg::fine_y_step(v_tick);
            end
            if (dot_reg == vsat_pkg::HCOPY_DOT) begin
                v_tick = (v_tick & vsat_pkg::HORIZ_KEEP) |
                         ({1'b0, taddr_reg} & vsat_pkg::HORIZ_BITS);
            end
            if ((line_reg == vsat_pkg::LAST_LINE) && (dot_reg >= vsat_pkg::VCOPY_FIRST) &&
                (dot_reg <= vsat_pkg::VCOPY_LAST)) begin
                v_tick = (v_tick & vsat_pkg::HORIZ_BITS) |
                         ({1'b0, taddr_reg} & vsat_pkg::HORIZ_KEEP);
            end
        end
    end

    always_comb begin
        vaddr_next        = vaddr_reg;
        taddr_next        = taddr_reg;
        fine_x_next       = fine_x_reg;
        second_write_next = second_write_reg;
        vblank_next       = vblank_reg;
        nmi_next          = nmi_reg;
        nmi_enable_next   = nmi_enable_reg;
        step_by_row_next  = step_by_row_reg;
        render_on_next    = render_on_reg;
        dot_next          = dot_reg;
        line_next         = line_reg;
        is_status         = 1'b0;
        is_ack            = 1'b0;
        unique case (item.opcode)
            vsat_pkg::OP_TICK: begin
                vaddr_next = v_tick;
                if ((line_reg == vsat_pkg::VBLANK_LINE) && (dot_reg == vsat_pkg::FLAG_DOT)) begin
                    vblank_next = 1'b1;
                    if (nmi_enable_reg) begin
                        nmi_next = 1'b1;
                    end
                end
                if ((line_reg == vsat_pkg::LAST_LINE) && (dot_reg == vsat_pkg::FLAG_DOT)) begin
                    vblank_next = 1'b0;
                end
                if (dot_reg >= vsat_pkg::LAST_DOT) begin
                    dot_next  = '0;
                    line_next = (line_reg >= vsat_pkg::LAST_LINE) ? '0 : line_reg + 9'd1;
                end else begin
                    dot_next = dot_reg + 9'd1;
                end
            end
            vsat_pkg::OP_CTRL: begin
                nmi_enable_next  = item.data_byte[7];
                step_by_row_next = item.data_byte[2];
                taddr_next       = (taddr_reg & vsat_pkg::CTRL_KEEP) |
                                   {3'd0, item.data_byte[1:0], 10'd0};
            end
            vsat_pkg::OP_MASK: begin
                render_on_next = item.data_byte[3] || item.data_byte[4];
            end
            vsat_pkg::OP_SCROLL: begin
                if (second_write_reg) begin
                    taddr_next = (taddr_reg & vsat_pkg::SCROLL2_KEEP) |
                                 {item.data_byte[2:0], 2'd0, item.data_byte[7:3], 5'd0};
                end else begin
                    taddr_next  = (taddr_reg & vsat_pkg::SCROLL1_KEEP) |
                                  {10'd0, item.data_byte[7:3]};
                    fine_x_next = item.data_byte[2:0];
                end
                second_write_next = !second_write_reg;
            end
            vsat_pkg::OP_ADDR: begin
                if (second_write_reg) begin
                    taddr_next = (taddr_reg & vsat_pkg::ADDR2_KEEP) | d15;
                    vaddr_next = {1'b0, (taddr_reg & vsat_pkg::ADDR2_KEEP) | d15};
                end else begin
                    taddr_next = (taddr_reg & vsat_pkg::ADDR1_KEEP) |
                                 {1'b0, item.data_byte[5:0], 8'd0};
                end
                second_write_next = !second_write_reg;
            end
            vsat_pkg::OP_STATUS: begin
                is_status         = 1'b1;
                vblank_next       = 1'b0;
                second_write_next = 1'b0;
            end
            vsat_pkg::OP_DATA: begin
                vaddr_next = vaddr_reg + (step_by_row_reg ? vsat_pkg::ROW_STEP
                                                          : vsat_pkg::COL_STEP);
            end
            vsat_pkg::OP_NMIACK: begin
                is_ack   = 1'b1;
                nmi_next = 1'b0;
            end
            default: begin
                is_ack = 1'b0;
            end
        endcase
    end

    // status and acknowledge report the flag as it was before the clear
    assign status_old = is_status ? vblank_reg : vblank_next;
    assign nmi_old    = is_ack ? nmi_reg : nmi_next;

    always_comb begin
        result.current_address = vaddr_next;
        result.temp_address    = taddr_next;
        result.fine_scroll_x   = fine_x_next;
        result.toggle_state    = second_write_next;
        result.status_value    = {status_old, 7'd0};
        result.nmi_pending     = nmi_old;
        result.dot_count       = dot_next;
        result.line_count      = line_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vaddr_reg        <= '0;
            taddr_reg        <= '0;
            fine_x_reg       <= '0;
            second_write_reg <= 1'b0;
            vblank_reg       <= 1'b0;
            nmi_reg          <= 1'b0;
            nmi_enable_reg   <= 1'b0;
            step_by_row_reg  <= 1'b0;
            render_on_reg    <= 1'b0;
            dot_reg          <= '0;
            line_reg         <= '0;
        end else if (step_en) begin
            vaddr_reg        <= vaddr_next;
            taddr_reg        <= taddr_next;
            fine_x_reg       <= fine_x_next;
            second_write_reg <= second_write_next;
            vblank_reg       <= vblank_next;
            nmi_reg          <= nmi_next;
            nmi_enable_reg   <= nmi_enable_next;
            step_by_row_reg  <= step_by_row_next;
            render_on_reg    <= render_on_next;
            dot_reg          <= dot_next;
            line_reg         <= line_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vsat_out_stage.sv =====
// Result register of the video scroll address timing unit.
// Holds one result item for the master stream; uses vsat_pkg.
`default_nettype none

module vsat_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  vsat_pkg::result_t     in_result,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output vsat_pkg::result_t     out_result
);

    logic              valid_reg;
    logic              valid_next;
    vsat_pkg::result_t result_reg;

    // load while empty or while the held item is taken
    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= in_result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/video_scroll_address_timing_unit.sv =====
// Video scroll address timing unit: input register, state update core, result register.
// Uses vsat_pkg, vsat_in_stage, vsat_core and vsat_out_stage.
//
// Usage: each slave-stream item is either a dot tick or a CPU register access
// (control, mask, scroll, address write, status read, data access, NMI ack).
// Every item yields exactly one master-stream item with the current and
// temporary video addresses, fine x scroll, write toggle, status byte,
// pending NMI flag and the dot and scanline position.
// Each result passes through the input register and then the result register.
// Throughput: one item per cycle while the master side is not stalled; the
// whole state update for an item is applied in the single cycle it moves
// from the input to the result register.
// Reset (aresetn low, synchronous) clears all address, flag and raster state
// and empties both registers. When the receiver stalls, the result is held,
// the input register takes one more item only if empty, then s_axis_tready drops.
`default_nettype none

module video_scroll_address_timing_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode [2:0], data_byte [10:3], zero [15:11]
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // current_address [15:0], temp_address [30:16], fine_scroll_x [33:31],
    // toggle_state [34], status_value [42:35], nmi_pending [43],
    // dot_count [52:44], line_count [61:53], zero [63:62]
    output logic [63:0]      m_axis_tdata
);

    vsat_pkg::item_t   s_item;
    vsat_pkg::item_t   core_item;
    vsat_pkg::result_t core_result;
    vsat_pkg::result_t m_result;
    logic              core_valid;
    logic              core_ready;

    assign s_item.opcode    = s_axis_tdata[2:0];
    assign s_item.data_byte = s_axis_tdata[10:3];

    vsat_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (s_item),
        .out_valid (core_valid),
        .out_ready (core_ready),
        .out_item  (core_item)
    );

    vsat_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (core_valid && core_ready),
        .item    (core_item),
        .result  (core_result)
    );

    vsat_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (core_valid),
        .in_ready   (core_ready),
        .in_result  (core_result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (m_result)
    );

    assign m_axis_tdata = {2'b00, m_result};

endmodule

`default_nettype wire
